/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CRIF_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CRIF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/crif_pkg.sv */
// ----------------------------------------------------------------------------
// crif_pkg
// Codes, command and status types shared by the controller and datapath.
// ----------------------------------------------------------------------------
package crif_pkg;

   localparam int RATIO_W = 24;

   localparam logic [1:0] FUNC_RING1  = 2'd0;
   localparam logic [1:0] FUNC_RING2  = 2'd1;
   localparam logic [1:0] FUNC_CENTER = 2'd2;
   localparam logic [1:0] FUNC_FINAL  = 2'd3;

   localparam logic KIND_REGION = 1'b0;
   localparam logic KIND_CELL   = 1'b1;

   typedef enum logic {
      MUL_NQ = 1'b0,
      MUL_SS = 1'b1
   } mul_sel_type;

   typedef enum logic [2:0] {
      DJ_MEAN = 3'd0,
      DJ_SD   = 3'd1,
      DJ_CELL = 3'd2,
      DJ_R1C  = 3'd3,
      DJ_R2C  = 3'd4,
      DJ_R12  = 3'd5
   } div_job_type;

   typedef struct packed {
      logic        load;
      logic        mul_load;
      mul_sel_type mul_sel;
      logic        mul_step;
      logic        sqrt_load;
      logic        sqrt_step;
      logic        div_load;
      logic        div_step;
      logic        div_store;
      div_job_type div_job;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic is_final;
      logic out_free;
   } status_type;

endpackage

/* hdl/crif_ctrl.sv */
// ----------------------------------------------------------------------------
// crif_ctrl
// Sequencer: multiply passes, square root, divider jobs, result write.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crif_ctrl #(
   parameter int COUNT_BITS = 20,
   parameter int PIXEL_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  crif_pkg::status_type status,
   output crif_pkg::cmd_type    cmd
);

   localparam int CNT_W   = COUNT_BITS + 1;
   localparam int SUM_W   = PIXEL_BITS + COUNT_BITS;
   localparam int SQ_W    = 2 * PIXEL_BITS + COUNT_BITS;
   localparam int SACC_W  = PIXEL_BITS + COUNT_BITS + 2;
   localparam int MEAN_W  = PIXEL_BITS + 8;
   localparam int PW      = SQ_W + CNT_W;
   localparam int XW      = PW + 16;
   localparam int XE      = XW + (XW % 2);
   localparam int RW      = XE / 2;
   localparam int DN1     = SUM_W + 8;
   localparam int DN2     = (RW > DN1) ? RW : DN1;
   localparam int DN3     = (SACC_W + 8 > DN2) ? SACC_W + 8 : DN2;
   localparam int DNW     = (MEAN_W + 16 > DN3) ? MEAN_W + 16 : DN3;
   localparam int MS1     = (RW > SUM_W) ? RW : SUM_W;
   localparam int MAXS    = (DNW > MS1) ? DNW : MS1;
   localparam int CW      = $clog2(MAXS);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_START   = 9'b000000010,
      S_MUL     = 9'b000000100,
      S_MULNEXT = 9'b000001000,
      S_SQRT    = 9'b000010000,
      S_DLOAD   = 9'b000100000,
      S_DIV     = 9'b001000000,
      S_DSTORE  = 9'b010000000,
      S_DONE    = 9'b100000000
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   crif_pkg::div_job_type job_ff, job_in;
   crif_pkg::mul_sel_type pass_ff, pass_in;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      job_in     = job_ff;
      pass_in    = pass_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.div_job = job_ff;
      case (state_ff)
         S_IDLE: begin
            // no transfer while in reset
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            cnt_in = '0;
            if (status.is_final) begin
               job_in   = crif_pkg::DJ_CELL;
               state_in = S_DLOAD;
            end else begin
               cmd.mul_load = 1'b1;
               cmd.mul_sel  = crif_pkg::MUL_NQ;
               pass_in      = crif_pkg::MUL_NQ;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(SUM_W - 1)) begin
               cnt_in   = '0;
               state_in = S_MULNEXT;
            end
         end
         S_MULNEXT: begin
            if (pass_ff == crif_pkg::MUL_NQ) begin
               cmd.mul_load = 1'b1;
               cmd.mul_sel  = crif_pkg::MUL_SS;
               pass_in      = crif_pkg::MUL_SS;
               state_in     = S_MUL;
            end else begin
               cmd.sqrt_load = 1'b1;
               state_in      = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CW'(RW - 1)) begin
               cnt_in   = '0;
               job_in   = crif_pkg::DJ_MEAN;
               state_in = S_DLOAD;
            end
         end
         S_DLOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DNW - 1)) begin
               cnt_in   = '0;
               state_in = S_DSTORE;
            end
         end
         S_DSTORE: begin
            cmd.div_store = 1'b1;
            state_in      = S_DLOAD;
            case (job_ff)
               crif_pkg::DJ_MEAN: job_in = crif_pkg::DJ_SD;
               crif_pkg::DJ_CELL: job_in = crif_pkg::DJ_R1C;
               crif_pkg::DJ_R1C:  job_in = crif_pkg::DJ_R2C;
               crif_pkg::DJ_R2C:  job_in = crif_pkg::DJ_R12;
               default:           state_in = S_DONE;
            endcase
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         job_ff   <= crif_pkg::DJ_MEAN;
         pass_ff  <= crif_pkg::MUL_NQ;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         job_ff   <= job_in;
         pass_ff  <= pass_in;
      end
   end

   `CRIF_ASSERT_IMPL(a_finish_free, cmd.finish, status.out_free, "result written over busy slot")
   `CRIF_ASSERT_NEXT(a_accept_start, req_tvalid && req_tready, state_ff == S_START, "no start")

endmodule

/* hdl/crif_dp.sv */
// ----------------------------------------------------------------------------
// crif_dp
// Datapath: shift-add multiplier, bit-serial square root, restoring divider,
// cell state and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crif_dp #(
   parameter int COUNT_BITS = 20,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  crif_pkg::cmd_type                    cmd,
   output crif_pkg::status_type                 status,
   input  logic [1:0]                           in_func,
   input  logic [COUNT_BITS:0]                  in_count,
   input  logic [PIXEL_BITS+COUNT_BITS-1:0]     in_sum,
   input  logic [2*PIXEL_BITS+COUNT_BITS-1:0]   in_sumsq,
   input  logic                                 rsp_tready,
   output logic                                 rsp_valid,
   output logic                                 o_kind,
   output logic [PIXEL_BITS+7:0]                o_mean,
   output logic [PIXEL_BITS+7:0]                o_sd,
   output logic [COUNT_BITS:0]                  o_area,
   output logic [PIXEL_BITS+7:0]                o_cmean,
   output logic [COUNT_BITS+1:0]                o_carea,
   output logic [crif_pkg::RATIO_W-1:0]         o_r1c,
   output logic [crif_pkg::RATIO_W-1:0]         o_r2c,
   output logic [crif_pkg::RATIO_W-1:0]         o_r12,
   output logic                                 o_crv,
   output logic                                 o_rrv,
   output logic                                 o_empty
);

   localparam int CNT_W   = COUNT_BITS + 1;
   localparam int SUM_W   = PIXEL_BITS + COUNT_BITS;
   localparam int SQ_W    = 2 * PIXEL_BITS + COUNT_BITS;
   localparam int AREA_W  = COUNT_BITS + 2;
   localparam int SACC_W  = PIXEL_BITS + COUNT_BITS + 2;
   localparam int MEAN_W  = PIXEL_BITS + 8;
   localparam int RT_W    = crif_pkg::RATIO_W;
   localparam int PW      = SQ_W + CNT_W;
   localparam int XW      = PW + 16;
   localparam int XE      = XW + (XW % 2);
   localparam int RW      = XE / 2;
   localparam int DN1     = SUM_W + 8;
   localparam int DN2     = (RW > DN1) ? RW : DN1;
   localparam int DN3     = (SACC_W + 8 > DN2) ? SACC_W + 8 : DN2;
   localparam int DNW     = (MEAN_W + 16 > DN3) ? MEAN_W + 16 : DN3;
   localparam int DD1     = (AREA_W > CNT_W) ? AREA_W : CNT_W;
   localparam int DDW     = (MEAN_W > DD1) ? MEAN_W : DD1;

   // captured item
   logic [1:0]         func_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [SUM_W-1:0]   s_ff;
   logic [SQ_W-1:0]    q_ff;
   // multiplier
   logic [PW-1:0]      a_ff, p_ff, nq_ff;
   logic [SUM_W-1:0]   b_ff;
   // square root
   logic [XE-1:0]      x_ff;
   logic [RW+1:0]      srem_ff;
   logic [RW-1:0]      root_ff;
   // divider
   logic [DNW-1:0]     dq_ff;
   logic [DDW-1:0]     drem_ff, dden_ff;
   // quotients
   logic [MEAN_W-1:0]  mean_ff, sd_ff, cmean_ff;
   logic [RT_W-1:0]    r1c_ff, r2c_ff, r12_ff;
   // cell state
   logic [AREA_W-1:0]  area_ff;
   logic [SACC_W-1:0]  sacc_ff;
   logic [MEAN_W-1:0]  r1_ff, r2_ff, ctr_ff;
   logic               rsp_valid_ff;

   logic [PW-1:0]      diff;
   logic [RW+3:0]      s_rt, s_trial;
   logic               s_ge;
   logic [DDW:0]       d_rt, d_den;
   logic               d_ge;
   logic [MEAN_W-1:0]  q_mean;
   logic [RT_W-1:0]    q_ratio;
   logic [AREA_W:0]    area_sum;
   logic [SACC_W:0]    sacc_sum;
   logic               is_final;

   assign is_final        = (func_ff == crif_pkg::FUNC_FINAL);
   assign status.is_final = is_final;
   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_valid       = rsp_valid_ff;

   assign diff    = nq_ff - p_ff;
   assign s_rt    = {srem_ff, x_ff[XE-1 -: 2]};
   assign s_trial = (RW+4)'({root_ff, 2'b01});
   assign s_ge    = (s_rt >= s_trial);
   assign d_rt    = {drem_ff, dq_ff[DNW-1]};
   assign d_den   = {1'b0, dden_ff};
   assign d_ge    = (d_rt >= d_den);
   assign q_mean  = (|dq_ff[DNW-1:MEAN_W]) ? {MEAN_W{1'b1}} : dq_ff[MEAN_W-1:0];
   assign q_ratio = (|dq_ff[DNW-1:RT_W]) ? {RT_W{1'b1}} : dq_ff[RT_W-1:0];
   assign area_sum = (AREA_W+1)'(area_ff) + (AREA_W+1)'(n_ff);
   assign sacc_sum = (SACC_W+1)'(sacc_ff) + (SACC_W+1)'(s_ff);

   // arithmetic units, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= in_func;
         n_ff    <= in_count;
         s_ff    <= in_sum;
         q_ff    <= in_sumsq;
      end
      if (cmd.mul_load) begin
         p_ff <= '0;
         if (cmd.mul_sel == crif_pkg::MUL_SS) begin
            nq_ff <= p_ff;
            a_ff  <= PW'(s_ff);
            b_ff  <= s_ff;
         end else begin
            a_ff  <= PW'(q_ff);
            b_ff  <= SUM_W'(n_ff);
         end
      end else if (cmd.mul_step) begin
         if (b_ff[0]) p_ff <= p_ff + a_ff;
         a_ff <= {a_ff[PW-2:0], 1'b0};
         b_ff <= {1'b0, b_ff[SUM_W-1:1]};
      end
      if (cmd.sqrt_load) begin
         x_ff    <= (p_ff <= nq_ff) ? XE'({diff, 16'd0}) : '0;
         srem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         x_ff    <= {x_ff[XE-3:0], 2'b00};
         srem_ff <= s_ge ? (RW+2)'(s_rt - s_trial) : (RW+2)'(s_rt);
         root_ff <= {root_ff[RW-2:0], s_ge};
      end
      if (cmd.div_load) begin
         drem_ff <= '0;
         case (cmd.div_job)
            crif_pkg::DJ_MEAN: begin
               dq_ff <= DNW'({s_ff, 8'd0});       dden_ff <= DDW'(n_ff);
            end
            crif_pkg::DJ_SD: begin
               dq_ff <= DNW'(root_ff);            dden_ff <= DDW'(n_ff);
            end
            crif_pkg::DJ_CELL: begin
               dq_ff <= DNW'({sacc_ff, 8'd0});    dden_ff <= DDW'(area_ff);
            end
            crif_pkg::DJ_R1C: begin
               dq_ff <= DNW'({r1_ff, 16'd0});     dden_ff <= DDW'(ctr_ff);
            end
            crif_pkg::DJ_R2C: begin
               dq_ff <= DNW'({r2_ff, 16'd0});     dden_ff <= DDW'(ctr_ff);
            end
            default: begin
               dq_ff <= DNW'({r1_ff, 16'd0});     dden_ff <= DDW'(r2_ff);
            end
         endcase
      end else if (cmd.div_step) begin
         drem_ff <= d_ge ? DDW'(d_rt - d_den) : DDW'(d_rt);
         dq_ff   <= {dq_ff[DNW-2:0], d_ge};
      end
      // zero divisors give 0
      if (cmd.div_store) begin
         case (cmd.div_job)
            crif_pkg::DJ_MEAN: mean_ff  <= (n_ff == '0) ? '0 : q_mean;
            crif_pkg::DJ_SD:   sd_ff    <= (n_ff == '0) ? '0 : q_mean;
            crif_pkg::DJ_CELL: cmean_ff <= (area_ff == '0) ? '0 : q_mean;
            crif_pkg::DJ_R1C:  r1c_ff   <= (ctr_ff == '0) ? '0 : q_ratio;
            crif_pkg::DJ_R2C:  r2c_ff   <= (ctr_ff == '0) ? '0 : q_ratio;
            default:           r12_ff   <= (r2_ff == '0) ? '0 : q_ratio;
         endcase
      end
      if (cmd.finish) begin
         if (is_final) begin
            o_kind  <= crif_pkg::KIND_CELL;
            o_mean  <= '0;
            o_sd    <= '0;
            o_area  <= '0;
            o_cmean <= cmean_ff;
            o_carea <= area_ff;
            o_r1c   <= r1c_ff;
            o_r2c   <= r2c_ff;
            o_r12   <= r12_ff;
            o_crv   <= (ctr_ff != '0);
            o_rrv   <= (r2_ff != '0);
            o_empty <= (area_ff == '0);
         end else begin
            o_kind  <= crif_pkg::KIND_REGION;
            o_mean  <= mean_ff;
            o_sd    <= sd_ff;
            o_area  <= n_ff;
            o_cmean <= '0;
            o_carea <= '0;
            o_r1c   <= '0;
            o_r2c   <= '0;
            o_r12   <= '0;
            o_crv   <= 1'b0;
            o_rrv   <= 1'b0;
            o_empty <= (n_ff == '0);
         end
      end
   end

   // cell state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         area_ff      <= '0;
         sacc_ff      <= '0;
         r1_ff        <= '0;
         r2_ff        <= '0;
         ctr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.finish) begin
            if (is_final) begin
               area_ff <= '0;
               sacc_ff <= '0;
               r1_ff   <= '0;
               r2_ff   <= '0;
               ctr_ff  <= '0;
            end else begin
               area_ff <= area_sum[AREA_W] ? {AREA_W{1'b1}} : area_sum[AREA_W-1:0];
               sacc_ff <= sacc_sum[SACC_W] ? {SACC_W{1'b1}} : sacc_sum[SACC_W-1:0];
               case (func_ff)
                  crif_pkg::FUNC_RING1: r1_ff  <= mean_ff;
                  crif_pkg::FUNC_RING2: r2_ff  <= mean_ff;
                  default:              ctr_ff <= mean_ff;
               endcase
            end
         end
      end
   end

   `CRIF_ASSERT_NEXT(a_finish_valid, cmd.finish, rsp_valid_ff, "result not presented")
   `CRIF_ASSERT_NEXT(a_final_clear, cmd.finish && is_final, area_ff == '0 && sacc_ff == '0, "cell state not cleared")

endmodule

/* hdl/cell_region_intensity_features.sv */
// ----------------------------------------------------------------------------
// cell_region_intensity_features
// Region mean / std deviation from moments, cell mean and mean ratios.
// ----------------------------------------------------------------------------
// One item at a time. A region item (ring 1, ring 2, center) returns mean and
// population standard deviation in Q16.8 plus its pixel count, and adds into
// the cell area and sum. A finalize item returns the cell mean, cell area and
// three saturating Q8.16 mean ratios with valid flags, then clears the cell.
// A region item runs both multiplier passes, the root and two divider jobs
// (mean, deviation); a finalize item runs four divider jobs (cell mean and
// the three ratios). The shift-add multiplier (one bit of the multiplier per
// cycle, two passes for n*Q and S*S), the square root (one root bit per
// cycle) and the restoring divider (one quotient bit per cycle, DNW bits per
// job) do this work. The result sits in an output register, so the next
// item is taken while a result still waits.
// ----------------------------------------------------------------------------
module cell_region_intensity_features #(
   parameter int COUNT_BITS = 20,
   parameter int PIXEL_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // input item
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // fields from bit 0: pixel_count, intensity_sum, intensity_sum_squares, zero pad
   input  logic [((3*COUNT_BITS+3*PIXEL_BITS+1+7)/8)*8-1:0] req_tdata,
   // fields from bit 0: func
   input  logic [1:0]           req_tuser,
   // result item
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // fields from bit 0: region_mean, region_std_dev, region_area, cell_mean,
   // cell_area, ring1_over_center, ring2_over_center, ring1_over_ring2,
   // center_ratios_valid, ring_ratio_valid, empty_region, zero pad
   output logic [((3*(PIXEL_BITS+8)+2*COUNT_BITS+3+3*crif_pkg::RATIO_W+3+7)/8)*8-1:0]
                                rsp_tdata,
   // fields from bit 0: result_kind
   output logic                 rsp_tuser
);

   localparam int CNT_W  = COUNT_BITS + 1;
   localparam int SUM_W  = PIXEL_BITS + COUNT_BITS;
   localparam int SQ_W   = 2 * PIXEL_BITS + COUNT_BITS;
   localparam int AREA_W = COUNT_BITS + 2;
   localparam int MEAN_W = PIXEL_BITS + 8;
   localparam int RT_W   = crif_pkg::RATIO_W;
   localparam int ODW    = $bits(rsp_tdata);

   crif_pkg::cmd_type    cmd;
   crif_pkg::status_type status;

   logic [MEAN_W-1:0] o_mean, o_sd, o_cmean;
   logic [CNT_W-1:0]  o_area;
   logic [AREA_W-1:0] o_carea;
   logic [RT_W-1:0]   o_r1c, o_r2c, o_r12;
   logic              o_crv, o_rrv, o_empty;

   crif_ctrl #(
      .COUNT_BITS (COUNT_BITS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   crif_dp #(
      .COUNT_BITS (COUNT_BITS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_func    (req_tuser),
      .in_count   (req_tdata[CNT_W-1:0]),
      .in_sum     (req_tdata[CNT_W+SUM_W-1:CNT_W]),
      .in_sumsq   (req_tdata[CNT_W+SUM_W+SQ_W-1:CNT_W+SUM_W]),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .o_kind     (rsp_tuser),
      .o_mean     (o_mean),
      .o_sd       (o_sd),
      .o_area     (o_area),
      .o_cmean    (o_cmean),
      .o_carea    (o_carea),
      .o_r1c      (o_r1c),
      .o_r2c      (o_r2c),
      .o_r12      (o_r12),
      .o_crv      (o_crv),
      .o_rrv      (o_rrv),
      .o_empty    (o_empty)
   );

   // pack the result transfer, first field lowest
   assign rsp_tdata = ODW'({o_empty, o_rrv, o_crv, o_r12, o_r2c, o_r1c,
                            o_carea, o_cmean, o_area, o_sd, o_mean});

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cell_region_intensity_features: drives region and
// finalize transfers, predicts each result from a local model of the moment
// arithmetic and cell state, and compares every result field by field.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DATA_IN_W  = 112;
   localparam int DATA_OUT_W = 192;
   localparam int MEAN_W     = 24;
   localparam int AREA_ACC_W = 22;
   localparam int SUM_ACC_W  = 38;
   localparam int TARGET_ITEMS = 1400;

   // result layout: tuser on top, then tdata fields from the highest bit down
   typedef struct packed {
      logic        kind;
      logic [1:0]  pad;
      logic        empty_region;
      logic        ring_ratio_valid;
      logic        center_ratios_valid;
      logic [23:0] ring1_over_ring2;
      logic [23:0] ring2_over_center;
      logic [23:0] ring1_over_center;
      logic [21:0] cell_area;
      logic [23:0] cell_mean;
      logic [20:0] region_area;
      logic [23:0] region_std_dev;
      logic [23:0] region_mean;
   } features_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DATA_IN_W-1:0]  req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [DATA_OUT_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   // predictor copy of the cell state
   bit [21:0] area_acc;
   bit [37:0] sum_acc;
   bit [23:0] ring1_mean, ring2_mean, center_mean;

   features_type pending_features[$];
   int        errors = 0;
   int        items_sent = 0;
   bit        quiet = 0;      // no idling on either side
   bit        hold_long = 0;  // receiver long hold-off request
   bit        checks_done = 0;

   cell_region_intensity_features dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   function automatic bit [63:0] sat(bit [63:0] v, int w);
      bit [63:0] m;
      m = (64'd1 << w) - 1;
      return (v > m) ? m : v;
   endfunction

   // floor square root, one root bit per step
   function automatic bit [47:0] floor_sqrt(bit [95:0] v);
      bit [47:0] r;
      bit [95:0] t;
      r = '0;
      for (int b = 47; b >= 0; b--) begin
         t = 96'(r | (48'd1 << b));
         if (t * t <= v) r = t[47:0];
      end
      return r;
   endfunction

   function automatic bit [23:0] mean_ratio(bit [23:0] num, bit [23:0] den);
      if (den == 0) return '0;
      return 24'(sat((64'(num) << 16) / den, 24));
   endfunction

   // expected result of one accepted item; updates the cell state
   function automatic features_type predict_features(bit [1:0] f, bit [20:0] n,
                                                     bit [35:0] s, bit [51:0] q);
      features_type r;
      bit [95:0] nq, ss, x;
      bit [23:0] mean;
      r = '0;
      if (f != crif_pkg::FUNC_FINAL) begin
         mean = '0;
         if (n == 0) begin
            r.empty_region = 1'b1;
         end else begin
            nq = 96'(n) * 96'(q);
            ss = 96'(s) * 96'(s);
            mean = 24'(sat((64'(s) << 8) / n, MEAN_W));
            if (ss <= nq) begin
               x = (nq - ss) << 16;   // 256^2 scale inside the root
               r.region_std_dev = 24'(sat(64'(floor_sqrt(x)) / n, MEAN_W));
            end
         end
         case (f)
            crif_pkg::FUNC_RING1: ring1_mean = mean;
            crif_pkg::FUNC_RING2: ring2_mean = mean;
            default:              center_mean = mean;
         endcase
         area_acc = 22'(sat(64'(area_acc) + n, AREA_ACC_W));
         sum_acc  = 38'(sat(64'(sum_acc) + s, SUM_ACC_W));
         r.kind        = crif_pkg::KIND_REGION;
         r.region_mean = mean;
         r.region_area = n;
      end else begin
         r.kind = crif_pkg::KIND_CELL;
         if (area_acc == 0) r.empty_region = 1'b1;
         else r.cell_mean = 24'(sat((64'(sum_acc) << 8) / area_acc, MEAN_W));
         r.cell_area = area_acc;
         if (center_mean > 0) begin
            r.ring1_over_center   = mean_ratio(ring1_mean, center_mean);
            r.ring2_over_center   = mean_ratio(ring2_mean, center_mean);
            r.center_ratios_valid = 1'b1;
         end
         if (ring2_mean > 0) begin
            r.ring1_over_ring2 = mean_ratio(ring1_mean, ring2_mean);
            r.ring_ratio_valid = 1'b1;
         end
         area_acc = '0; sum_acc = '0;
         ring1_mean = '0; ring2_mean = '0; center_mean = '0;
      end
      return r;
   endfunction

   function automatic bit [63:0] rand_bits(int w);
      return {$urandom, $urandom} & ((64'd1 << w) - 1);
   endfunction

   // one input transfer; prediction taken at the accepting edge
   task automatic send_item(bit [1:0] f, bit [20:0] n, bit [35:0] s, bit [51:0] q);
      req_tuser  <= f;
      req_tdata  <= {3'b000, q, s, n};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_features.push_back(predict_features(f, n, s, q));
      items_sent++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // region with plausible moments: n pixels around mean m with spread v
   task automatic send_region(bit [1:0] f);
      bit [20:0] n;
      bit [63:0] m, v;
      case ($urandom_range(0, 9))
         0:       n = 21'(rand_bits(21));
         1:       n = 21'(1 << 20);
         2:       n = 21'($urandom_range(0, 1));
         default: n = 21'($urandom_range(1, 4000));
      endcase
      m = $urandom_range(0, 3) == 0 ? rand_bits(8) : rand_bits(16);
      v = rand_bits($urandom_range(0, 28));
      send_item(f, n, 36'(n * m + $urandom_range(0, 1)),
                52'(n * m * m + n * v));
   endtask

   task automatic send_noise();
      send_item(2'(rand_bits(2)), 21'(rand_bits(21)), 36'(rand_bits(36)),
                52'(rand_bits(52)));
   endtask

   task automatic send_cell();
      repeat ($urandom_range(0, 5)) send_region(2'($urandom_range(0, 2)));
      send_item(crif_pkg::FUNC_FINAL, 21'(rand_bits(21)), 36'(rand_bits(36)),
                52'(rand_bits(52)));
   endtask

   // extremes, empty and inconsistent regions, one item of each kind
   task automatic test_region_corners();
      send_item(crif_pkg::FUNC_RING1, '0, 36'd1234, 52'd99);       // empty region
      send_item(crif_pkg::FUNC_RING2, '1, '1, '1);                   // all ones
      send_item(crif_pkg::FUNC_CENTER, 21'd1, '1, '0);               // mean saturates
      send_item(crif_pkg::FUNC_FINAL, '0, '0, '0);
      send_item(crif_pkg::FUNC_RING1, 21'd4, 36'd400, 52'd10);       // n*Q < S*S
      send_item(crif_pkg::FUNC_CENTER, 21'(1 << 20), 36'h0_FFFF_0000,
                52'h0_FFFE_0001_0000);
      send_item(crif_pkg::FUNC_FINAL, '1, '1, '1);
   endtask

   // empty cell, saturating ratios, zero divisor means
   task automatic test_cell_corners();
      send_item(crif_pkg::FUNC_FINAL, '0, '0, '0);                   // empty cell
      send_item(crif_pkg::FUNC_RING1, 21'd1, 36'd65535, 52'd65535 * 65535);
      send_item(crif_pkg::FUNC_RING2, 21'd1, 36'd1, 52'd1);
      send_item(crif_pkg::FUNC_CENTER, 21'd256, 36'd1, 52'd1);       // tiny center mean
      send_item(crif_pkg::FUNC_FINAL, '0, '0, '0);                   // ratios saturate
      send_item(crif_pkg::FUNC_RING1, 21'd10, 36'd500, 52'd25000);
      send_item(crif_pkg::FUNC_CENTER, '0, 36'd77, '0);              // center mean zero
      send_item(crif_pkg::FUNC_FINAL, '0, '0, '0);
      repeat (3) send_item(crif_pkg::FUNC_RING1, '1, '1, '0);        // cell area saturates
      send_item(crif_pkg::FUNC_RING2, 21'd3, 36'd300, 52'd30000);
      send_item(crif_pkg::FUNC_FINAL, '0, '0, '0);
   endtask

   // receiver stops for a long stretch while items keep coming
   task automatic test_output_stall();
      hold_long = 1'b1;
      repeat (6) send_region(2'($urandom_range(0, 2)));
      send_item(crif_pkg::FUNC_FINAL, '0, '0, '0);
   endtask

   task automatic test_random_cells();
      while (items_sent < TARGET_ITEMS - 200) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         else send_cell();
      end
   endtask

   // closing part with both sides always ready
   task automatic test_steady_stream();
      quiet = 1'b1;
      while (items_sent < TARGET_ITEMS) send_cell();
      req_tvalid <= 1'b0;
   endtask

   task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp, act);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      features_type act, exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act = {rsp_tuser, rsp_tdata};
         if (pending_features.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %0h", $realtime, act);
         end else begin
            exp = pending_features.pop_front();
            check_field("result_kind", exp.kind, act.kind);
            check_field("region_mean", exp.region_mean, act.region_mean);
            check_field("region_std_dev", exp.region_std_dev, act.region_std_dev);
            check_field("region_area", exp.region_area, act.region_area);
            check_field("cell_mean", exp.cell_mean, act.cell_mean);
            check_field("cell_area", exp.cell_area, act.cell_area);
            check_field("ring1_over_center", exp.ring1_over_center, act.ring1_over_center);
            check_field("ring2_over_center", exp.ring2_over_center, act.ring2_over_center);
            check_field("ring1_over_ring2", exp.ring1_over_ring2, act.ring1_over_ring2);
            check_field("center_ratios_valid", exp.center_ratios_valid,
                        act.center_ratios_valid);
            check_field("ring_ratio_valid", exp.ring_ratio_valid, act.ring_ratio_valid);
            check_field("empty_region", exp.empty_region, act.empty_region);
         end
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int stall_cycles;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_long) begin
            rsp_tready <= 1'b0;
            stall_cycles = 0;
            while (stall_cycles < 600) begin
               @(posedge clock);
               stall_cycles++;
            end
            hold_long = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = crif_pkg::FUNC_RING1;
      area_acc = '0; sum_acc = '0;
      ring1_mean = '0; ring2_mean = '0; center_mean = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_region_corners();
      test_cell_corners();
      test_output_stall();
      test_random_cells();
      test_steady_stream();
      while (pending_features.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);   // time for stray results
      checks_done = 1'b1;
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   // run limit, well above the slowest correct run
   initial begin
      #20ms;
      if (!checks_done) $display("CHECK FAILED");
      $finish;
   end

endmodule
